// ===== sv/fia_pkg.sv =====
// fia_pkg: shared types and constants of the first-free id allocator.
// No dependencies; imported by the top level and its checker.
package fia_pkg;

	localparam int ID_W   = 16;
	localparam int WORD_W = 64;
	localparam int BIT_W  = 6;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_MOD  = 1'b1
	} fsm_t;

	localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

endpackage

// ===== sv/fia_ram.sv =====
// fia_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/first_free_id_allocator.sv =====
// first_free_id_allocator: bitmap id allocator, lowest free id first.
// Depends on fia_pkg and fia_ram.
//
// channel  dir  beat fields (tdata / tuser)
// s_*      in   release_id / cmd
// m_*      out  granted_id / status
// cfg_*    in   base_id, written whenever cfg_we is high
//
// Each command reads the bitmap word, then modifies it and writes it back
// through the single RAM port pair. A per-word full map in flops picks
// the word to read for allocate. Reset and free-all clear per-word valid
// bits at once, so no clearing pass is needed. A stalled result holds the
// modify state; a new command is taken while the previous result still
// waits on m_tready.
module first_free_id_allocator
	import fia_pkg::*;
#(
	parameter int NUM_IDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] release_id
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] granted_id
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
	localparam int WAW       = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
	localparam logic [16:0] NUM_IDS_L = 17'(NUM_IDS);

	fsm_t state_q, state_d;

	logic [ID_W-1:0]   base_q;
	logic [NUM_WORDS-1:0] vld_q, full_q;

	cmd_t              cmd_s1;
	logic [WAW-1:0]    word_s1;
	logic [BIT_W-1:0]  bit_s1;
	logic              nonfull_s1;
	logic              oor_s1;

	logic              m_tvalid_q;
	logic [ID_W-1:0]   m_tdata_q;
	status_t           m_tuser_q;

	logic              accept, done;
	logic              ram_we, ram_re;
	logic [WAW-1:0]    ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata, cur_word;

	logic [16:0]       room, count, diff;
	logic [WAW-1:0]    free_word;
	logic              any_nonfull;
	logic [BIT_W-1:0]  free_bit;
	logic              bit_found;
	logic [16:0]       alloc_idx;
	logic              alloc_ok;

	assign s_tready = (state_q == FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign done     = (state_q == FSM_MOD) && (!m_tvalid_q || m_tready);

	assign room  = 17'h10000 - {1'b0, base_q};
	assign count = (NUM_IDS_L < room) ? NUM_IDS_L : room;
	assign diff  = {1'b0, s_tdata} - {1'b0, base_q};

	always_comb begin
		free_word   = '0;
		any_nonfull = 1'b0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				free_word   = WAW'(i);
				any_nonfull = 1'b1;
			end
		end
	end

	assign cur_word = vld_q[word_s1] ? ram_rdata : '0;

	always_comb begin
		free_bit  = '0;
		bit_found = 1'b0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!cur_word[i]) begin
				free_bit  = BIT_W'(i);
				bit_found = 1'b1;
			end
		end
	end

	assign alloc_idx = 17'({word_s1, free_bit});
	assign alloc_ok  = nonfull_s1 && bit_found && (alloc_idx < count);

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = free_word;
		ram_we    = 1'b0;
		ram_wdata = cur_word;
		if (cmd_t'(s_tuser) == CMD_RELEASE) begin
			ram_raddr = diff[BIT_W +: WAW];
		end
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					ram_re  = 1'b1;
					state_d = FSM_MOD;
				end
			end
			FSM_MOD: begin
				if (done) begin
					state_d = FSM_IDLE;
					if (cmd_s1 == CMD_ALLOC && alloc_ok) begin
						ram_we = 1'b1;
						ram_wdata[free_bit] = 1'b1;
					end else if (cmd_s1 == CMD_RELEASE && !oor_s1) begin
						ram_we = 1'b1;
						ram_wdata[bit_s1] = 1'b0;
					end
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= BASE_RESET;
			vld_q      <= '0;
			full_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
				if (cmd_s1 == CMD_CLEAR) begin
					vld_q  <= '0;
					full_q <= '0;
				end else if (ram_we) begin
					vld_q[word_s1]  <= 1'b1;
					full_q[word_s1] <= &ram_wdata;
				end
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_t'(s_tuser);
			nonfull_s1 <= any_nonfull;
			oor_s1     <= diff[16] || (diff >= count);
			bit_s1     <= diff[BIT_W-1:0];
			word_s1    <= (cmd_t'(s_tuser) == CMD_RELEASE) ? diff[BIT_W +: WAW] : free_word;
		end
		if (done) begin
			unique case (cmd_s1)
				CMD_ALLOC: begin
					if (alloc_ok) begin
						m_tdata_q <= base_q + alloc_idx[ID_W-1:0];
						m_tuser_q <= ST_OK;
					end else begin
						m_tdata_q <= '0;
						m_tuser_q <= ST_EMPTY;
					end
				end
				CMD_RELEASE: begin
					m_tdata_q <= '0;
					m_tuser_q <= oor_s1 ? ST_RANGE : ST_OK;
				end
				default: begin
					m_tdata_q <= '0;
					m_tuser_q <= ST_OK;
				end
			endcase
		end
	end

	fia_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(word_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== sv/fia_chk.sv =====
// fia_chk: port-level checks of first_free_id_allocator, bound to the top.
// Depends on fia_pkg.
module fia_chk
	import fia_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while one is in work");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata == 16'd0)
		else $error("granted id not zero on failure");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result beat with no command in work");

endmodule

bind first_free_id_allocator fia_chk u_fia_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
